>>> hdl/threshold_vector_grouping_assert.svh
// Assertion macros shared by the threshold vector grouping RTL.
`ifndef THRESHOLD_VECTOR_GROUPING_ASSERT_SVH
`define THRESHOLD_VECTOR_GROUPING_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define TVG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define TVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tvg_pkg.sv
// Package: beat types, controller states, command/status structs and constants.
`timescale 1ns / 1ps
`default_nettype none

package tvg_pkg;

  localparam int unsigned TRAIT_W       = 16;
  localparam int unsigned PREC_W        = 16;
  localparam int unsigned SQ_W          = 32;
  localparam int unsigned GIDX_W        = 6;
  localparam logic [SQ_W-1:0] PREC_SQ_RESET = 32'h0001_0000;

  typedef struct packed {
    logic signed [TRAIT_W-1:0] trait_value;
    logic                      last_of_vector;
    logic                      start_new_set;
  } in_beat_t;

  typedef struct packed {
    logic [GIDX_W-1:0] group_index;
    logic              is_new_group;
    logic              store_overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT
  } tvg_state_e;

  typedef struct packed {
    logic take;
    logic prep;
    logic scan;
    logic write;
    logic emit;
  } tvg_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic room;
    logic write_done;
    logic out_free;
  } tvg_status_t;

endpackage

`default_nettype wire

>>> hdl/tvg_ctrl.sv
// Controller state machine: sequences gather, limit setup, scan, store write and result.
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_vector_grouping_assert.svh"

module tvg_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_last_i,
  input  wire tvg_pkg::tvg_status_t status_i,
  output tvg_pkg::tvg_cmd_t        cmd_o,
  output logic                     in_stall_o
);
  import tvg_pkg::*;

  tvg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_LIMIT;
      end
      ST_LIMIT: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          if (status_i.found || !status_i.room) state_d = ST_EMIT;
          else state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status_i.write_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      ST_LIMIT: begin
        cmd_o.prep = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `TVG_ASSERT_NEXT(a_limit_to_scan, state_q == ST_LIMIT, state_q == ST_SCAN, "limit not followed by scan")
  `TVG_ASSERT_SAME(a_no_write_on_match, state_q == ST_WRITE, !status_i.found, "store write after a match")
  `TVG_ASSERT_NEXT(a_emit_to_idle, cmd_o.emit, state_q == ST_IDLE, "emit did not return to idle")

endmodule

`default_nettype wire

>>> hdl/tvg_dp.sv
// Datapath: vector buffer, representative store, distance pipeline, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_vector_grouping_assert.svh"

module tvg_dp #(
  parameter int unsigned MAX_GROUPS = 64,
  parameter int unsigned MAX_TRAITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tvg_pkg::in_beat_t    in_beat_i,
  input  wire tvg_pkg::tvg_cmd_t    cmd_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 out_stall_i,
  output tvg_pkg::tvg_status_t      status_o,
  output logic                      out_valid_o,
  output tvg_pkg::out_beat_t        out_beat_o
);
  import tvg_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_TRAITS + 1);
  localparam int unsigned TW    = (MAX_TRAITS > 1) ? $clog2(MAX_TRAITS) : 1;
  localparam int unsigned GW    = $clog2(MAX_GROUPS);
  localparam int unsigned GCW   = $clog2(MAX_GROUPS + 1);
  localparam int unsigned DEPTH = MAX_GROUPS * MAX_TRAITS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = AW + 1;
  localparam int unsigned LW    = SQ_W + CW;

  // Memories
  logic signed [TRAIT_W-1:0] cur_mem   [MAX_TRAITS];
  logic signed [TRAIT_W-1:0] store_mem [DEPTH];

  // Gather state
  logic [CW-1:0]  elem_cnt_q;
  logic [CW-1:0]  n_q;
  logic [GCW-1:0] group_cnt_q;
  logic [SQ_W-1:0] p2_q;
  logic [LW-1:0]  limit_q;

  // Walk counters
  logic [GCW-1:0] g_q;
  logic [CW-1:0]  k_q;
  logic [BW-1:0]  base_q;

  // Pipeline
  logic                      v1_q, l1_q, w1_q;
  logic [GW-1:0]             g1_q;
  logic [CW-1:0]             k1_q;
  logic signed [TRAIT_W-1:0] cur_rd_q, rep_rd_q;
  logic                      v2_q, l2_q;
  logic [GW-1:0]             g2_q;
  logic [SQ_W-1:0]           sq_q;
  logic [LW-1:0]             acc_q;
  logic                      found_q;
  logic [GW-1:0]             midx_q;

  logic                      out_valid_q;
  out_beat_t                 out_beat_q;

  // Combinational
  logic [CW-1:0]             cnt_base, cnt_next, k_inc;
  logic                      elem_room, last_elem, issue_scan, issue_wr;
  logic                      room, match_now;
  logic [BW-1:0]             rd_sum, wr_sum;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic signed [TRAIT_W:0]   diff;
  logic signed [2*TRAIT_W+1:0] prod;
  logic [LW-1:0]             total;
  logic [GW-1:0]             idx_sel;
  logic [GW+GIDX_W-1:0]      idx_ext;

  assign cnt_base  = in_beat_i.start_new_set ? '0 : elem_cnt_q;
  assign elem_room = cnt_base < CW'(MAX_TRAITS);
  assign cnt_next  = elem_room ? cnt_base + CW'(1) : cnt_base;

  assign room      = group_cnt_q < GCW'(MAX_GROUPS);
  assign k_inc     = k_q + CW'(1);
  assign last_elem = (k_inc == n_q);

  assign total     = acc_q + LW'(sq_q);
  assign match_now = v2_q && l2_q && (total < limit_q);

  assign issue_scan = cmd_i.scan && !found_q && !match_now && (g_q < group_cnt_q);
  assign issue_wr   = cmd_i.write && (k_q < CW'(MAX_TRAITS));

  assign rd_sum  = base_q + BW'(k_q);
  assign rd_addr = rd_sum[AW-1:0];
  assign wr_sum  = base_q + BW'(k1_q);
  assign wr_addr = wr_sum[AW-1:0];

  assign diff = {cur_rd_q[TRAIT_W-1], cur_rd_q} - {rep_rd_q[TRAIT_W-1], rep_rd_q};
  assign prod = diff * diff;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt_q  <= '0;
      group_cnt_q <= '0;
      p2_q        <= PREC_SQ_RESET;
      g_q         <= '0;
      k_q         <= '0;
      base_q      <= '0;
      v1_q        <= 1'b0;
      w1_q        <= 1'b0;
      v2_q        <= 1'b0;
      found_q     <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        p2_q <= SQ_W'(cfg_wdata_i) * SQ_W'(cfg_wdata_i);
      end

      if (cmd_i.take) begin
        elem_cnt_q <= in_beat_i.last_of_vector ? '0 : cnt_next;
        if (in_beat_i.start_new_set) group_cnt_q <= '0;
      end else if (cmd_i.emit && !found_q && room) begin
        group_cnt_q <= group_cnt_q + GCW'(1);
      end

      // Walk the store row by row, element by element.
      if (cmd_i.prep) begin
        g_q    <= '0;
        k_q    <= '0;
        base_q <= '0;
      end else if (issue_scan) begin
        if (last_elem) begin
          k_q    <= '0;
          g_q    <= g_q + GCW'(1);
          base_q <= base_q + BW'(MAX_TRAITS);
        end else begin
          k_q <= k_inc;
        end
      end else if (issue_wr) begin
        k_q <= k_inc;
      end

      // The pipeline is already empty when the limit is prepared.
      v1_q <= issue_scan;
      w1_q <= issue_wr;
      v2_q <= v1_q && !match_now;

      // Sum squares per row; the first row under the limit wins.
      if (cmd_i.prep) begin
        acc_q   <= '0;
        found_q <= 1'b0;
      end else if (v2_q) begin
        if (l2_q) begin
          acc_q <= '0;
          if (match_now) found_q <= 1'b1;
        end else begin
          acc_q <= total;
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_beat_i.last_of_vector) n_q <= cnt_next;
    if (cmd_i.prep) limit_q <= LW'(n_q) * LW'(p2_q);
    l1_q <= last_elem;
    g1_q <= g_q[GW-1:0];
    k1_q <= k_q;
    l2_q <= l1_q;
    g2_q <= g1_q;
    sq_q <= prod[SQ_W-1:0];
    if (match_now) midx_q <= g2_q;
    if (cmd_i.emit) begin
      out_beat_q.group_index    <= idx_ext[GIDX_W-1:0];
      out_beat_q.is_new_group   <= !found_q && room;
      out_beat_q.store_overflow <= !found_q && !room;
    end
  end

  // Vector buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && elem_room) cur_mem[cnt_base[TW-1:0]] <= in_beat_i.trait_value;
    cur_rd_q <= cur_mem[k_q[TW-1:0]];
  end

  // Representative store; zero-pad the row past the vector length.
  always_ff @(posedge clk_i) begin
    if (w1_q) store_mem[wr_addr] <= (k1_q < n_q) ? cur_rd_q : '0;
    rep_rd_q <= store_mem[rd_addr];
  end

  always_comb begin
    if (found_q) idx_sel = midx_q;
    else if (room) idx_sel = group_cnt_q[GW-1:0];
    else idx_sel = '0;
  end
  assign idx_ext = {{GIDX_W{1'b0}}, idx_sel};

  assign status_o.scan_done  = found_q || ((g_q == group_cnt_q) && !v1_q && !v2_q);
  assign status_o.found      = found_q;
  assign status_o.room       = room;
  assign status_o.write_done = (k_q == CW'(MAX_TRAITS)) && !w1_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `TVG_ASSERT_SAME(a_grp_cnt_bound, 1'b1, group_cnt_q <= GCW'(MAX_GROUPS), "group count above store depth")
  `TVG_ASSERT_SAME(a_match_below_cnt, found_q && cmd_i.scan, GCW'(midx_q) < group_cnt_q, "match index beyond stored rows")
  `TVG_ASSERT_SAME(a_wr_has_room, w1_q, room, "store write with full store")
  `TVG_ASSERT_NEXT(a_emit_loads, cmd_i.emit, out_valid_q, "emit did not load the result register")

endmodule

`default_nettype wire

>>> hdl/threshold_vector_grouping.sv
// Top level: leader clustering of trait vectors by mean squared distance.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i): one trait element per
//   beat, signed Q8.8. last_of_vector closes a vector; start_new_set on an
//   element drops the stored representatives and any partly gathered vector.
//   Output channel (out_valid_o / out_stall_i / out_beat_o): one result beat per
//   finished vector, giving group index, new-group flag and overflow flag.
//   Configuration: cfg_we_i writes precision (unsigned Q8.8) from cfg_wdata_i;
//   write only while the block is idle. Reset value is 1.0.
// Timing:
//   Elements that do not close a vector are taken one per cycle.
//   A closing element starts the limit setup and the store walk (G stored rows,
//   n elements in the vector, one squared difference per cycle through one
//   multiplier, then the pipeline drains), then the write of the vector as a new
//   row when no match is found and the store has room, then the load of the
//   result register. A match ends the walk early.
//   The input is stalled until the result is loaded; non-closing elements may enter
//   while the previous result still waits in the output register.
// Reset: empties the set and the vector, clears output valid.
// Stalled output: the result beat holds; a new closing vector waits for it.
`timescale 1ns / 1ps
`default_nettype none

module threshold_vector_grouping #(
  parameter int unsigned MAX_GROUPS = 64,
  parameter int unsigned MAX_TRAITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tvg_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tvg_pkg::out_beat_t      out_beat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i
);
  import tvg_pkg::*;

  // Commands down to the datapath, status back up.
  tvg_cmd_t    cmd;
  tvg_status_t status;

  // Sequence gather, limit, walk, write and result.
  tvg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_beat_i.last_of_vector),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Hold the vector buffer, the store and the distance pipeline.
  tvg_dp #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_TRAITS (MAX_TRAITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
